### src/ofe_pkg.sv
// ----------------------------------------------------------------------------
// ofe_pkg
// Shared types, constants and helpers of the optical frame encoder.
// ----------------------------------------------------------------------------
package ofe_pkg;

  localparam int unsigned RepW   = 10;
  localparam int unsigned MaskW  = 18;
  localparam int unsigned SlotN  = 6;

  // register indexes of the configuration port
  localparam logic [1:0] REG_SYNC  = 2'd0;
  localparam logic [1:0] REG_PAUSE = 2'd1;
  localparam logic [1:0] REG_START = 2'd2;
  localparam logic [1:0] REG_GAP   = 2'd3;

  localparam logic [RepW-1:0] SYNC_RST  = 10'd400;
  localparam logic [RepW-1:0] PAUSE_RST = 10'd10;
  localparam logic [RepW-1:0] START_RST = 10'd50;
  localparam logic [RepW-1:0] GAP_RST   = 10'd10;

  localparam logic [7:0] BYTE_SYNC  = 8'h55;
  localparam logic [7:0] BYTE_START = 8'haa;
  localparam logic [7:0] BYTE_IDLE  = 8'hff;

  // descriptor slots of one item, sent lowest first
  localparam int unsigned SL_SYNC   = 0;
  localparam int unsigned SL_PAUSE0 = 1;
  localparam int unsigned SL_START  = 2;
  localparam int unsigned SL_PAUSE1 = 3;
  localparam int unsigned SL_DATA   = 4;
  localparam int unsigned SL_GAP    = 5;

  typedef logic [SlotN-1:0] pend_t;

  typedef struct packed {
    logic [MaskW-1:0] lit_slots;
    logic [RepW-1:0]  repeat_res;
    logic             last;
  } desc_t;

  function automatic logic [MaskW-1:0] make_mask(input logic s0, input logic [7:0] b0,
                                                 input logic s1, input logic [7:0] b1);
    return {~b1, s1, ~b0, s0};
  endfunction

  function automatic logic [RepW-1:0] clamp_rep(input logic [RepW-1:0] r);
    return (r == '0) ? RepW'(1) : r;
  endfunction

  localparam logic [MaskW-1:0] MASK_SYNC  = make_mask(1'b1, BYTE_SYNC, 1'b1, BYTE_SYNC);
  localparam logic [MaskW-1:0] MASK_IDLE  = make_mask(1'b0, BYTE_IDLE, 1'b0, BYTE_IDLE);
  localparam logic [MaskW-1:0] MASK_START = make_mask(1'b1, BYTE_START, 1'b0, BYTE_IDLE);

endpackage

### src/optical_frame_encoder.sv
// ----------------------------------------------------------------------------
// optical_frame_encoder
// Pairs packet bytes into display frame descriptors, with session preamble
// and per-packet gap frames.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  s_*      | in        | s_tvalid / s_tready | data_byte, last_of_packet, session_start
//  m_*      | out       | m_tvalid / m_tready | lit_slots, repeat_res, last
//  cfg_*    | in        | cfg_we              | register index, 10-bit value
//
// An item passes a job register and then an output register. The job register
// sends one descriptor per cycle while m_tready does not stall it; an item has
// as many results as descriptors (0 to 6), and items with at most one result
// flow at one per cycle when not stalled. rst is synchronous and restores
// register defaults and clears the held byte. A stalled m_tready holds the
// output register; the job register then holds and s_tready drops.
// ----------------------------------------------------------------------------
module optical_frame_encoder (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // [7:0] data_byte
  input  logic                        s_tlast,   // last_of_packet
  input  logic                        s_tuser,   // session_start
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,   // [17:0] lit_slots, [27:18] repeat_res
  output logic                        m_tlast,   // last
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [ofe_pkg::RepW-1:0]    cfg_data
);
  import ofe_pkg::*;

  logic [RepW-1:0]  sync_frames, pause_frames, start_frames, gap_frames;
  logic [7:0]       held_byte;
  logic             held_valid;
  logic             job_valid;
  pend_t            job_pending;
  logic [MaskW-1:0] job_mask;
  desc_t            cur_desc;
  pend_t            pending_next;
  desc_t            out_desc;
  logic             out_load, job_done, accept;
  pend_t            new_pending;
  logic [MaskW-1:0] new_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_frames  <= SYNC_RST;
      pause_frames <= PAUSE_RST;
      start_frames <= START_RST;
      gap_frames   <= GAP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC:  sync_frames  <= cfg_data;
        REG_PAUSE: pause_frames <= cfg_data;
        REG_START: start_frames <= cfg_data;
        REG_GAP:   gap_frames   <= cfg_data;
        default: ;
      endcase
    end
  end

  ofe_desc u_desc (
    .pending      (job_pending),
    .data_mask    (job_mask),
    .sync_frames  (sync_frames),
    .pause_frames (pause_frames),
    .start_frames (start_frames),
    .gap_frames   (gap_frames),
    .desc         (cur_desc),
    .pending_next (pending_next)
  );

  assign out_load = job_valid && (!m_tvalid || m_tready);
  assign job_done = out_load && (pending_next == '0);
  assign s_tready = !job_valid || job_done;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    new_pending            = '0;
    new_pending[SL_SYNC]   = s_tuser;
    new_pending[SL_PAUSE0] = s_tuser;
    new_pending[SL_START]  = s_tuser;
    new_pending[SL_PAUSE1] = s_tuser;
    new_pending[SL_DATA]   = held_valid || s_tlast;
    new_pending[SL_GAP]    = s_tlast;
    // an odd final byte goes out alone with the second sync cleared
    new_mask = held_valid ? make_mask(1'b1, held_byte, 1'b1, s_tdata)
                          : make_mask(1'b1, s_tdata, 1'b0, BYTE_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_byte  <= '0;
    end else if (accept) begin
      if (held_valid) begin
        held_valid <= 1'b0;
        held_byte  <= '0;
      end else if (!s_tlast) begin
        held_valid <= 1'b1;
        held_byte  <= s_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid   <= 1'b0;
      job_pending <= '0;
    end else if (accept && new_pending != '0) begin
      job_valid   <= 1'b1;
      job_pending <= new_pending;
    end else if (job_done) begin
      job_valid   <= 1'b0;
      job_pending <= '0;
    end else if (out_load) begin
      job_pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job_mask <= new_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_desc <= cur_desc;
    end
  end

  assign m_tdata = {4'b0, out_desc.repeat_res, out_desc.lit_slots};
  assign m_tlast = out_desc.last;

  a_job_nonempty: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> job_pending != '0)
    else $error("job register valid with no pending descriptor");

  a_pair_clears: assert property (@(posedge clk) disable iff (rst)
    accept && held_valid |=> !held_valid)
    else $error("held byte survived pairing");

  a_job_retires: assert property (@(posedge clk) disable iff (rst)
    job_done && !accept |=> !job_valid)
    else $error("job register still valid after final descriptor");

  a_ready_drains: assert property (@(posedge clk) disable iff (rst)
    s_tready && job_valid |-> out_load)
    else $error("input taken while job register cannot drain");

endmodule

### src/ofe_desc.sv
// ----------------------------------------------------------------------------
// ofe_desc
// Picks the next pending descriptor slot of an item and builds its fields.
// ----------------------------------------------------------------------------
module ofe_desc (
  input  ofe_pkg::pend_t                 pending,
  input  logic [ofe_pkg::MaskW-1:0]      data_mask,
  input  logic [ofe_pkg::RepW-1:0]       sync_frames,
  input  logic [ofe_pkg::RepW-1:0]       pause_frames,
  input  logic [ofe_pkg::RepW-1:0]       start_frames,
  input  logic [ofe_pkg::RepW-1:0]       gap_frames,
  output ofe_pkg::desc_t                 desc,
  output ofe_pkg::pend_t                 pending_next
);
  import ofe_pkg::*;

  logic [MaskW-1:0] mask;
  logic [RepW-1:0]  rep;

  assign pending_next = pending & (pending - pend_t'(1));

  // lowest set slot wins
  always_comb begin
    mask = MASK_IDLE;
    rep  = gap_frames;
    if (pending[SL_SYNC]) begin
      mask = MASK_SYNC;
      rep  = sync_frames;
    end else if (pending[SL_PAUSE0] || pending[SL_PAUSE1] && !pending[SL_START]) begin
      mask = MASK_IDLE;
      rep  = pause_frames;
    end else if (pending[SL_START]) begin
      mask = MASK_START;
      rep  = start_frames;
    end else if (pending[SL_DATA]) begin
      mask = data_mask;
      rep  = RepW'(1);
    end
  end

  assign desc.lit_slots  = mask;
  assign desc.repeat_res = clamp_rep(rep);
  assign desc.last       = (pending_next == '0);

endmodule
